// ===== sv/escd_pkg.sv =====
// escd_pkg: shared types and constants for the escape sequence decoder
// used by escd_decode and escape_sequence_decoder_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package escd_pkg;

  localparam int OutMax = 4;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  // parser state carried from one word to the next
  typedef struct packed {
    mode_t       mode;
    logic        short_hex;
    logic [2:0]  digit_count;
    logic [15:0] code_value;
  } escd_state_t;

  // decoded run for one input word
  typedef struct packed {
    logic [OutMax-1:0][7:0] bytes;
    logic [1:0]             last_idx;
    logic                   data;
  } escd_run_t;

endpackage

`default_nettype wire

// ===== sv/escd_decode.sv =====
// escd_decode: single-pass decode of one input byte against the parser state
// depends on escd_pkg; purely combinational
`timescale 1ns / 1ps
`default_nettype none

module escd_decode
  import escd_pkg::*;
(
  input  escd_state_t state,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output escd_state_t state_next,
  output escd_run_t   run
);

  logic        is_hex;
  logic [3:0]  hval;
  logic [15:0] code_shift;
  logic [2:0]  count_inc;
  logic        limit_hit;

  logic        do_flush;
  logic [15:0] fl_value;
  logic        fl_has_digit;
  logic        fl_short;
  logic [3:0][7:0] fb;
  logic [2:0]  fn;

  logic        text_esc;
  logic        text_plain;
  logic [7:0]  t0;
  logic [7:0]  t1;
  logic [1:0]  tn;
  logic [2:0]  total;
  logic [2:0]  k;

  // hex digit classification
  always_comb begin
    is_hex = 1'b1;
    hval   = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      hval = 4'(in_byte - 8'h30);
    end else if (in_byte inside {[8'h41:8'h46]}) begin
      hval = 4'(in_byte - 8'h37);
    end else if (in_byte inside {[8'h61:8'h66]}) begin
      hval = 4'(in_byte - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign code_shift = {state.code_value[11:0], hval};
  assign count_inc  = state.digit_count + 3'd1;
  assign limit_hit  = state.short_hex ? (count_inc >= 3'd2) : (count_inc >= 3'd4);

  // main control: state update, flush source and text path
  always_comb begin
    state_next   = '{mode: MODE_PLAIN, short_hex: 1'b0, digit_count: 3'd0,
                     code_value: 16'd0};
    do_flush     = 1'b0;
    fl_value     = 16'd0;
    fl_has_digit = 1'b0;
    fl_short     = 1'b0;
    text_esc     = 1'b0;
    text_plain   = 1'b0;
    case (state.mode)
      MODE_HEX: begin
        if (is_hex) begin
          fl_value     = code_shift;
          fl_has_digit = 1'b1;
          fl_short     = state.short_hex;
          do_flush     = limit_hit || in_last;
          if (!limit_hit) begin
            state_next.mode        = MODE_HEX;
            state_next.short_hex   = state.short_hex;
            state_next.digit_count = count_inc;
            state_next.code_value  = code_shift;
          end
        end else begin
          // escape ends early: emit value, then treat this byte as text
          do_flush     = 1'b1;
          fl_value     = state.code_value;
          fl_has_digit = (state.digit_count != 3'd0);
          fl_short     = state.short_hex;
          text_plain   = 1'b1;
        end
      end
      MODE_ESC: begin
        text_esc = 1'b1;
        if (in_byte == "x" || in_byte == "u") begin
          state_next.mode      = MODE_HEX;
          state_next.short_hex = (in_byte == "x");
          // no digit yet, so end of string gives the letter
          do_flush = in_last;
          fl_short = (in_byte == "x");
        end
      end
      default: begin
        text_plain = 1'b1;
      end
    endcase
    if (text_plain && in_byte == "\\") begin
      state_next.mode = MODE_ESC;
    end
    if (in_last) begin
      state_next = '{mode: MODE_PLAIN, short_hex: 1'b0, digit_count: 3'd0,
                     code_value: 16'd0};
    end
  end

  // utf-8 encoding of a finished hex escape
  always_comb begin
    fb = '0;
    fn = 3'd0;
    if (do_flush) begin
      if (!fl_has_digit || fl_value == 16'd0) begin
        fb[0] = fl_short ? 8'("x") : 8'("u");
        fn    = 3'd1;
      end else if (fl_value < 16'h0080) begin
        fb[0] = fl_value[7:0];
        fn    = 3'd1;
      end else if (fl_value < 16'h0800) begin
        fb[0] = {3'b110, fl_value[10:6]};
        fb[1] = {2'b10, fl_value[5:0]};
        fn    = 3'd2;
      end else if (fl_value inside {[16'hD800:16'hDFFF]}) begin
        // lone surrogate becomes the replacement character
        fb[0] = 8'hEF;
        fb[1] = 8'hBF;
        fb[2] = 8'hBD;
        fn    = 3'd3;
      end else begin
        fb[0] = {4'b1110, fl_value[15:12]};
        fb[1] = {2'b10, fl_value[11:6]};
        fb[2] = {2'b10, fl_value[5:0]};
        fn    = 3'd3;
      end
    end
  end

  // text bytes after an escape or in plain text
  always_comb begin
    t0 = in_byte;
    t1 = in_byte;
    tn = 2'd0;
    if (text_esc) begin
      tn = 2'd1;
      if (in_byte inside {[8'h31:8'h39]}) begin
        t0 = "$";
        tn = 2'd2;
      end else begin
        case (in_byte)
          "a":     t0 = 8'h07;
          "b":     t0 = 8'h08;
          "f":     t0 = 8'h0C;
          "n":     t0 = 8'h0A;
          "r":     t0 = 8'h0D;
          "t":     t0 = 8'h09;
          "v":     t0 = 8'h0B;
          "\\":    tn = 2'd2;
          "x":     tn = 2'd0;
          "u":     tn = 2'd0;
          default: t0 = in_byte;
        endcase
      end
    end else if (text_plain && in_byte != "\\") begin
      tn = 2'd1;
    end
  end

  // pack flush bytes then text bytes; an empty run becomes one filler word
  always_comb begin
    total = fn + {1'b0, tn};
    run.bytes = '0;
    k = 3'd0;
    for (int i = 0; i < OutMax; i++) begin
      k = 3'(i) - fn;
      if (3'(i) < fn) begin
        run.bytes[i[1:0]] = fb[i[1:0]];
      end else if (3'(i) < total) begin
        run.bytes[i[1:0]] = (k == 3'd0) ? t0 : t1;
      end
    end
    run.data     = (total != 3'd0);
    run.last_idx = (total == 3'd0) ? 2'd0 : 2'(total - 3'd1);
  end

endmodule

`default_nettype wire

// ===== sv/escape_sequence_decoder_core.sv =====
// channel | direction | fields                          | handshake
// in      | into core | in_byte, in_last                | in_valid / in_stall
// out     | from core | out_byte, byte_valid, run_last  | out_valid / out_stall
//
// each input word yields a run of 1 to 4 output words, sent out through the
// single output port at one byte per cycle while out_stall is low
// an input register feeds the decoder; the run buffer is loaded as its previous
// run hands over its final word, so unstalled plain text flows at one per cycle
// rst (synchronous) returns the parser to plain text and empties both stages
// depends on escd_pkg and escd_decode
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_core
  import escd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_last
);

  escd_state_t state;
  escd_state_t state_next;
  escd_run_t   run_next;

  logic        inq_valid;
  logic [7:0]  inq_byte;
  logic        inq_last;

  escd_run_t   run_buf;
  logic        buf_valid;
  logic [1:0]  idx;

  logic        buf_free;
  logic        move;
  logic        load_in;

  escd_decode u_decode (
    .state      (state),
    .in_byte    (inq_byte),
    .in_last    (inq_last),
    .state_next (state_next),
    .run        (run_next)
  );

  assign run_last   = (idx == run_buf.last_idx);
  assign out_valid  = buf_valid;
  assign out_byte   = run_buf.bytes[idx];
  assign byte_valid = run_buf.data;

  assign buf_free = !buf_valid || (run_last && !out_stall);
  assign move     = inq_valid && buf_free;
  assign in_stall = inq_valid && !buf_free;
  assign load_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
      buf_valid <= 1'b0;
      idx       <= 2'd0;
      state     <= '{mode: MODE_PLAIN, short_hex: 1'b0, digit_count: 3'd0,
                     code_value: 16'd0};
    end else begin
      if (load_in) begin
        inq_valid <= 1'b1;
        inq_byte  <= in_byte;
        inq_last  <= in_last;
      end else if (move) begin
        inq_valid <= 1'b0;
      end

      if (move) begin
        state     <= state_next;
        run_buf   <= run_next;
        buf_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (buf_valid && !out_stall) begin
        if (run_last) begin
          buf_valid <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/escd_checker.sv =====
// escd_assertions: port-level checks on the escape sequence decoder
// bound to escape_sequence_decoder_core; no package needed
`timescale 1ns / 1ps
`default_nettype none

module escd_assertions (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       run_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled output word changed");

  // a filler word stands alone and carries zero
  a_filler: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> run_last && out_byte == 8'd0)
    else $error("filler word malformed");

  // a run keeps going without a gap until its last word
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid && byte_valid)
    else $error("run broken before its last word");

  // both stages empty after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("core not empty after reset");

endmodule

bind escape_sequence_decoder_core escd_assertions u_escd_assertions (.*);

`default_nettype wire
